@@ design/sssd_pkg.sv @@
`timescale 1ns / 1ps

package sssd_pkg;

  // Commands carried by an input word.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SET   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Glyph indexes beyond the ten decimal digits.
  localparam logic [3:0] GLYPH_POINT_ON  = 4'd10;
  localparam logic [3:0] GLYPH_POINT_OFF = 4'd11;

  // Digit extraction works on a fixed-point reciprocal with this many fraction bits.
  localparam int unsigned FRAC_BITS   = 30;
  localparam int unsigned RECIP_WIDTH = 27;
  localparam int unsigned NUM_WIDTH   = 16;
  localparam int unsigned PROD_WIDTH  = NUM_WIDTH + RECIP_WIDTH;
  localparam int unsigned SCALE_WIDTH = FRAC_BITS + 4;

  // One result word.
  typedef struct packed {
    logic [7:0]  segments_n;
    logic [3:0]  digit_enable;
    logic [15:0] shown_number;
  } result_t;

  // Rounded-up 2^30 / 10^(pos+1). The fraction of number * recip, times ten,
  // gives the decimal digit at that position for every 16-bit number.
  function automatic logic [RECIP_WIDTH-1:0] recip(input logic [1:0] pos);
    logic [RECIP_WIDTH-1:0] r;
    case (pos)
      2'd0:    r = 27'd107374183;
      2'd1:    r = 27'd10737419;
      2'd2:    r = 27'd1073742;
      2'd3:    r = 27'd107375;
      default: r = 27'd107374183;
    endcase
    return r;
  endfunction

  // Segment font, a..g in bits 0..6 and the point in bit 7, active high.
  function automatic logic [7:0] glyph(input logic [3:0] idx);
    logic [7:0] g;
    case (idx)
      4'd0:            g = 8'h3F;
      4'd1:            g = 8'h06;
      4'd2:            g = 8'h5B;
      4'd3:            g = 8'h4F;
      4'd4:            g = 8'h66;
      4'd5:            g = 8'h6D;
      4'd6:            g = 8'h7D;
      4'd7:            g = 8'h07;
      4'd8:            g = 8'h7F;
      4'd9:            g = 8'h6F;
      GLYPH_POINT_ON:  g = 8'h80;
      GLYPH_POINT_OFF: g = 8'h00;
      default:         g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

@@ design/sssd_ifs.sv @@
`timescale 1ns / 1ps

// Command channel into the driver.
interface sssd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] value;
  logic [3:0]  dp_bits;

  modport source (output valid, output cmd, output value, output dp_bits, input ready);
  modport sink   (input valid, input cmd, input value, input dp_bits, output ready);
endinterface

// Result channel out of the driver.
interface sssd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  segments_n;
  logic [3:0]  digit_enable;
  logic [15:0] shown_number;

  modport source (output valid, output segments_n, output digit_enable, output shown_number,
                  input ready);
  modport sink   (input valid, input segments_n, input digit_enable, input shown_number,
                  output ready);
endinterface

@@ design/seven_segment_scan_driver.sv @@
`timescale 1ns / 1ps

// Four-digit seven-segment scan driver. Every command word produces one result word that
// carries the held segment drive (active low), the one-hot digit enable (active high) and
// the stored display number. A scan tick advances the phase and drives one digit: phases
// 0 to 3 show the ones, tens, hundreds or thousands digit, phases 4 to 7 show only that
// digit's point. The block takes one word per cycle while the skid register is empty, and
// the digit comes from a single 16 x 27 reciprocal multiply in the accept cycle.
// Results wait in a result register backed by a skid register, so input stays open while
// one result is stalled and closes only when both hold words.
module seven_segment_scan_driver (
  input logic         clk_i,
  input logic         rst_ni,
  sssd_in_if.sink     in_i,
  sssd_out_if.source  out_o
);

  logic        in_fire;
  logic        out_fire;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] number_q, number_d;
  logic [3:0]  mask_q, mask_d;
  logic [7:0]  seg_q, seg_d;
  logic [3:0]  digit_q, digit_d;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  sssd_pkg::result_t out_data_q, out_data_d;
  sssd_pkg::result_t skid_data_q, skid_data_d;
  sssd_pkg::result_t result;

  logic [2:0]  tick_phase;
  logic [1:0]  pos;
  logic [sssd_pkg::PROD_WIDTH-1:0]  product;
  logic [sssd_pkg::FRAC_BITS-1:0]   frac;
  logic [sssd_pkg::SCALE_WIDTH-1:0] scaled;
  logic [3:0]  dec_digit;
  logic [3:0]  glyph_idx;
  sssd_pkg::cmd_e cmd;

  assign cmd      = sssd_pkg::cmd_e'(in_i.cmd);
  assign in_i.ready = !skid_valid_q;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;

  // Phase and digit position that a tick moves to.
  assign tick_phase = phase_q + 3'd1;
  assign pos        = tick_phase[1:0];

  // Decimal digit: fraction of number / 10^(pos+1), scaled by ten.
  assign product   = sssd_pkg::PROD_WIDTH'(number_q)
                   * sssd_pkg::PROD_WIDTH'(sssd_pkg::recip(pos));
  assign frac      = product[sssd_pkg::FRAC_BITS-1:0];
  assign scaled    = (sssd_pkg::SCALE_WIDTH'(frac) << 3) + (sssd_pkg::SCALE_WIDTH'(frac) << 1);
  assign dec_digit = scaled[sssd_pkg::SCALE_WIDTH-1:sssd_pkg::FRAC_BITS];

  // Digit glyph in the number phases, point only in the point phases.
  always_comb begin
    if (tick_phase[2]) begin
      glyph_idx = mask_q[pos] ? sssd_pkg::GLYPH_POINT_ON : sssd_pkg::GLYPH_POINT_OFF;
    end else begin
      glyph_idx = dec_digit;
    end
  end

  // Display state update for an accepted word.
  always_comb begin
    phase_d  = phase_q;
    number_d = number_q;
    mask_d   = mask_q;
    seg_d    = seg_q;
    digit_d  = digit_q;
    if (in_fire) begin
      case (cmd)
        sssd_pkg::CMD_TICK: begin
          phase_d = tick_phase;
          seg_d   = ~sssd_pkg::glyph(glyph_idx);
          digit_d = 4'(4'b0001 << pos);
        end
        sssd_pkg::CMD_WRITE: begin
          number_d = in_i.value;
        end
        sssd_pkg::CMD_SET: begin
          mask_d = mask_q | in_i.dp_bits;
        end
        sssd_pkg::CMD_CLEAR: begin
          mask_d = mask_q & ~in_i.dp_bits;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  assign result = '{segments_n: seg_d, digit_enable: digit_d, shown_number: number_d};

  // Result register with a skid register behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire;
        out_data_d  = result;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_data_d  = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 3'd0;
      number_q     <= 16'd0;
      mask_q       <= 4'd0;
      seg_q        <= 8'hFF;
      digit_q      <= 4'd0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      number_q     <= number_d;
      mask_q       <= mask_d;
      seg_q        <= seg_d;
      digit_q      <= digit_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.segments_n   = out_data_q.segments_n;
  assign out_o.digit_enable = out_data_q.digit_enable;
  assign out_o.shown_number = out_data_q.shown_number;

  // The skid register only fills behind a stalled result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without a result word in front");

  // At most one digit is driven at any time.
  a_digit_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(digit_q))
    else $error("more than one digit enabled");

  // A tick always leaves exactly one digit driven.
  a_tick_drives_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == sssd_pkg::CMD_TICK) |=> $onehot(digit_q))
    else $error("tick left no digit driven");

  // Commands other than a tick leave the scan position and drive alone.
  a_non_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd != sssd_pkg::CMD_TICK) |=> ($stable(phase_q) && $stable(seg_q)
                                                && $stable(digit_q)))
    else $error("scan state changed on a non-tick command");

  // In the point phases all digit segments are dark.
  a_point_phase_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q[2] && digit_q != 4'd0) |-> (&seg_q[6:0]))
    else $error("digit segment lit in a point phase");

endmodule
